// File: src/sorted_array_priority_queue_top_macros.svh
// Assertion macros shared by the RTL.
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define SAQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked while out of reset.
`define SAQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: src/saq_pkg.sv
// ----------------------------------------------------------------------------
// saq_pkg
// Types and constants of the sorted-array priority queue.
// ----------------------------------------------------------------------------
package saq_pkg;

    localparam int DEPTH    = 32;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int PRIO_W   = 16;
    localparam int TAG_W    = 16;
    localparam int OPCODE_W = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 6;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_NOP    = 2'd2
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]         tag;
    } entry_t;

    // Broadcast to every cell in the chain.
    typedef struct packed {
        logic   insert;
        logic   remove;
        entry_t new_entry;
    } cell_cmd_t;

endpackage

// File: src/saq_if.sv
// ----------------------------------------------------------------------------
// saq_req_if / saq_rsp_if
// Valid/ready channels carrying request and response words.
// ----------------------------------------------------------------------------
interface saq_req_if;
    import saq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OPCODE_W-1:0]      opcode;
    logic signed [PRIO_W-1:0] priority_req;
    logic [TAG_W-1:0]         tag;

    modport source (output valid, output opcode, output priority_req, output tag,
                    input ready);
    modport sink (input valid, input opcode, input priority_req, input tag,
                  output ready);
endinterface

interface saq_rsp_if;
    import saq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic                     top_valid;
    logic signed [PRIO_W-1:0] top_priority;
    logic [TAG_W-1:0]         top_tag;
    logic [COUNT_W-1:0]       entry_count;
    logic                     is_full;
    logic                     is_empty;

    modport source (output valid, output status, output top_valid, output top_priority,
                    output top_tag, output entry_count, output is_full, output is_empty,
                    input ready);
    modport sink (input valid, input status, input top_valid, input top_priority,
                  input top_tag, input entry_count, input is_full, input is_empty,
                  output ready);
endinterface

// File: src/saq_cell.sv
// ----------------------------------------------------------------------------
// saq_cell
// One slot of the sorted chain: holds an entry, compares it against the
// incoming priority and shifts with its neighbors on insert or remove.
// ----------------------------------------------------------------------------
module saq_cell (
    input  logic               clk,
    input  saq_pkg::cell_cmd_t cmd,
    input  logic               cell_valid,
    input  logic               prev_keep,
    input  saq_pkg::entry_t    prev_entry,
    input  saq_pkg::entry_t    succ_entry,
    output saq_pkg::entry_t    entry,
    output saq_pkg::entry_t    entry_next,
    output logic               keep
);
    import saq_pkg::*;

    entry_t entry_reg;

    // Chain is sorted high to low, so keep is set on a leading run of cells.
    // Equal priorities stay ahead of the new entry.
    assign keep = cell_valid && (entry_reg.prio >= cmd.new_entry.prio);

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.insert)
        begin
            if (!keep)
            begin
                entry_next = prev_keep ? cmd.new_entry : prev_entry;
            end
        end
        else if (cmd.remove)
        begin
            entry_next = succ_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// File: src/saq_chain.sv
// ----------------------------------------------------------------------------
// saq_chain
// Row of DEPTH cells; cell 0 holds the top entry.
// ----------------------------------------------------------------------------
module saq_chain (
    input  logic                      clk,
    input  saq_pkg::cell_cmd_t        cmd,
    input  logic [saq_pkg::CNT_W-1:0] count,
    output saq_pkg::entry_t           head_next
);
    import saq_pkg::*;

    entry_t ent      [DEPTH];
    entry_t ent_next [DEPTH];
    logic   keep     [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic   cell_valid;
            logic   prev_keep;
            entry_t prev_entry;
            entry_t succ_entry;

            assign cell_valid = count > CNT_W'(i);

            if (i == 0)
            begin : g_first
                assign prev_keep  = 1'b1;
                assign prev_entry = '0;
            end
            else
            begin : g_mid
                assign prev_keep  = keep[i-1];
                assign prev_entry = ent[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign succ_entry = ent[i];
            end
            else
            begin : g_inner
                assign succ_entry = ent[i+1];
            end

            saq_cell u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .cell_valid (cell_valid),
                .prev_keep  (prev_keep),
                .prev_entry (prev_entry),
                .succ_entry (succ_entry),
                .entry      (ent[i]),
                .entry_next (ent_next[i]),
                .keep       (keep[i])
            );
        end
    endgenerate

    assign head_next = ent_next[0];

endmodule

// File: src/sorted_array_priority_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_array_priority_queue_top
// Priority queue of up to DEPTH entries kept sorted in a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one word per operation: opcode (insert, remove top,
//   no-op), priority_req and tag. rsp channel returns one word per request:
//   status, the top entry after the operation, entry_count, is_full and
//   is_empty.
//   Every cell compares its entry with the incoming priority and shifts in
//   the same cycle, so one request is taken per cycle while req.ready is high;
//   the response word appears in the output register in the cycle after acceptance.
//   The output register is the only buffer: req.ready is high while it is
//   empty or being drained, so a stalled rsp side stalls req after one word.
//   Reset clears the entry count and the output valid; cell contents are
//   not cleared and are never shown past the count.
//   Equal priorities leave in insertion order.
// ----------------------------------------------------------------------------
`include "sorted_array_priority_queue_top_macros.svh"

module sorted_array_priority_queue_top (
    input  logic clk,
    input  logic rst_n,
    saq_req_if.sink   req,
    saq_rsp_if.source rsp
);
    import saq_pkg::*;

    logic [CNT_W-1:0]    count_reg, count_next;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [CNT_W-1:0]    out_count_reg;
    entry_t              top_reg;

    logic      accept, full, empty, do_ins, do_rem;
    status_t   status_next;
    cell_cmd_t cmd;
    entry_t    head_next;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign full      = count_reg == CNT_W'(DEPTH);
    assign empty     = count_reg == '0;

    always_comb
    begin
        do_ins      = 1'b0;
        do_rem      = 1'b0;
        status_next = ST_DONE;
        case (opcode_t'(req.opcode))
            OP_INSERT:
            begin
                if (full)
                    status_next = ST_FULL;
                else
                    do_ins = accept;
            end
            OP_REMOVE:
            begin
                if (empty)
                    status_next = ST_EMPTY;
                else
                    do_rem = accept;
            end
            default:
            begin
                status_next = ST_DONE;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
            count_next = count_reg + 1'b1;
        else if (do_rem)
            count_next = count_reg - 1'b1;
    end

    assign cmd.insert            = do_ins;
    assign cmd.remove            = do_rem;
    assign cmd.new_entry.prio    = req.priority_req;
    assign cmd.new_entry.tag     = req.tag;

    saq_chain u_chain (
        .clk       (clk),
        .cmd       (cmd),
        .count     (count_reg),
        .head_next (head_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_next;
            out_count_reg <= count_next;
            top_reg       <= (count_next != '0) ? head_next : '0;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.top_valid    = out_count_reg != '0;
    assign rsp.top_priority = top_reg.prio;
    assign rsp.top_tag      = top_reg.tag;
    assign rsp.entry_count  = COUNT_W'(out_count_reg);
    assign rsp.is_full      = out_count_reg == CNT_W'(DEPTH);
    assign rsp.is_empty     = out_count_reg == '0;

    `SAQ_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH))
    `SAQ_ASSERT_IMPL(a_full_status, clk, rst_n, rsp.valid && rsp.status == ST_FULL, rsp.is_full)
    `SAQ_ASSERT_NEXT(a_insert_count, clk, rst_n, do_ins, count_reg == $past(count_reg) + 1'b1)
    `SAQ_ASSERT_NEXT(a_remove_count, clk, rst_n, do_rem, count_reg == $past(count_reg) - 1'b1)

endmodule
